// File: sv/ial_pkg.sv
`default_nettype none
package ial_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // common width for comparing the 6-bit index field against the count
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_IDX = 2'd1,
    OP_DEL_VAL = 2'd2,
    OP_FIND    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  index;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [6:0] count;
    logic       empty_res;
  } out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] pos;
    word_t            word;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/ial_cell.sv
`default_nettype none
module ial_cell
  import ial_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire word_t            left_i,
  input  wire word_t            right_i,
  output word_t                 entry_o,
  output logic                  match_o
);

  word_t entry_q, entry_d;
  logic  live;

  assign live    = CNT_W'(cell_idx_i) < ctrl_i.count;
  assign match_o = live && (entry_q == ctrl_i.word);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (cell_idx_i == ctrl_i.pos) begin
          entry_d = ctrl_i.word;
        end else if (cell_idx_i > ctrl_i.pos) begin
          entry_d = left_i;
        end
      end
      CMD_REMOVE: begin
        if (cell_idx_i >= ctrl_i.pos) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

// File: sv/ial_prio.sv
`default_nettype none
module ial_prio
  import ial_pkg::*;
(
  input  wire logic [CAPACITY-1:0] match_i,
  output logic                     found_o,
  output logic [IDX_W-1:0]         pos_o
);

  // lowest set bit wins
  always_comb begin
    found_o = 1'b0;
    pos_o   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        found_o = 1'b1;
        pos_o   = IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/indexed_array_list.sv
`default_nettype none
// channel  direction  handshake                 word
// -------  ---------  ------------------------  ----------------------------
// in       input      in_valid_i / in_ready_o   in_data_i  (operation, index, value)
// out      output     out_valid_o / out_ready_i out_data_o (status, position, count,
//                                                           empty_res)
//
// An item passes through the steps accept, compare in every cell with the match
// bits registered, then priority encode and shift the whole chain at once.
// The next word is accepted in the cycle after the result is loaded, so the
// block takes no new word before it is through with the last one.
// A result not yet taken holds the apply step; the chain does not move then.
// Reset clears the count and the handshake state; entries are left as they are.
module indexed_array_list
  import ial_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_e;

  state_e              state_q, state_d;
  in_t                 op_q, op_d;
  logic [CAPACITY-1:0] match_q, match_d;
  logic [CNT_W-1:0]    count_q, count_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  cell_ctrl_t          ctrl;
  word_t               entry [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic                found;
  logic [IDX_W-1:0]    found_pos;
  logic [63:0]         value_ext;
  word_t               op_word;
  logic [CMP_W-1:0]    idx_ext, cnt_ext;
  logic                can_apply;

  assign value_ext = {{32{op_q.value[31]}}, op_q.value};
  assign op_word   = value_ext[DATA_WIDTH-1:0];
  assign idx_ext   = CMP_W'(op_q.index);
  assign cnt_ext   = CMP_W'(count_q);
  assign can_apply = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = entry[g];
    end else begin : g_right
      assign right = entry[g+1];
    end
    ial_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctrl_i     (ctrl),
      .left_i     (left),
      .right_i    (right),
      .entry_o    (entry[g]),
      .match_o    (match[g])
    );
  end

  ial_prio u_prio (
    .match_i (match_q),
    .found_o (found),
    .pos_o   (found_pos)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    match_d     = match_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    ctrl.cmd   = CMD_NONE;
    ctrl.pos   = '0;
    ctrl.word  = op_word;
    ctrl.count = count_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        match_d = match;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (can_apply) begin
          out_d.status   = ST_OK;
          out_d.position = '0;
          case (op_e'(op_q.operation))
            OP_INSERT: begin
              if (idx_ext > cnt_ext) begin
                out_d.status = ST_RANGE;
              end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                out_d.status = ST_FULL;
              end else begin
                ctrl.cmd       = CMD_INSERT;
                ctrl.pos       = IDX_W'(idx_ext);
                count_d        = count_q + 1'b1;
                out_d.position = op_q.index;
              end
            end
            OP_DEL_IDX: begin
              if (idx_ext >= cnt_ext) begin
                out_d.status = ST_RANGE;
              end else begin
                ctrl.cmd       = CMD_REMOVE;
                ctrl.pos       = IDX_W'(idx_ext);
                count_d        = count_q - 1'b1;
                out_d.position = op_q.index;
              end
            end
            OP_DEL_VAL: begin
              if (!found) begin
                out_d.status = ST_ABSENT;
              end else begin
                ctrl.cmd       = CMD_REMOVE;
                ctrl.pos       = found_pos;
                count_d        = count_q - 1'b1;
                out_d.position = 6'(found_pos);
              end
            end
            OP_FIND: begin
              if (!found) begin
                out_d.status = ST_ABSENT;
              end else begin
                out_d.position = 6'(found_pos);
              end
            end
            default: out_d.status = ST_OK;
          endcase
          out_d.count     = 7'(count_d);
          out_d.empty_res = (count_d == '0);
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      op_q        <= '0;
      match_q     <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      match_q     <= match_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
